/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pufc_pkg.sv */
package pufc_pkg;
    localparam int unsigned NODE_COUNT_DEF  = 1024;
    localparam int unsigned WEIGHT_BITS_DEF = 32;
    localparam int unsigned NODE_W          = 10;
    localparam int unsigned WORD_W          = 32;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_WALK_A,
        ST_FIX_A,
        ST_RD_B,
        ST_WALK_B,
        ST_FIX_B,
        ST_DECIDE,
        ST_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clear;     // write singleton at clear pointer
        logic load;      // capture input word
        logic sel_b;     // walk from node b instead of node a
        logic rd_start;  // issue read of start node
        logic rd_next;   // issue read of current parent
        logic fix_start; // restart at start node for compression
        logic fix_step;  // rewrite current node, issue read of next
        logic save_a;    // keep root/parity of endpoint a
        logic decide;    // join or flag conflict
        logic emit;      // enable conflict and merged result flags
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;  // clearing pass at final entry
        logic valid_in;  // both nodes in range and not frozen
        logic at_root;   // node just read is its own parent
        logic fix_done;  // compression reached the root
    } t_stat;
endpackage

/* hw/rtl/pufc_ram.sv */
module pufc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/pufc_dp.sv */
module pufc_dp
    import pufc_pkg::*;
#(
    parameter int unsigned NODE_COUNT  = NODE_COUNT_DEF,
    parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [WORD_W-1:0] i_weight,
    output logic              o_conflict,
    output logic              o_merged,
    output logic              o_found,
    output logic [WORD_W-1:0] o_answer
);
    localparam int unsigned AW = $clog2(NODE_COUNT);
    localparam int unsigned EW = AW + 1;   // parent plus parity
    localparam int unsigned WW = (WEIGHT_BITS < WORD_W) ? WEIGHT_BITS : WORD_W;

    // Input word registers.
    logic [NODE_W-1:0] r_na, r_nb;
    logic [WW-1:0]     r_w;

    // Walk registers.
    logic [AW-1:0] r_cur, n_cur;
    logic          r_acc, n_acc;
    logic [AW-1:0] r_root;
    logic          r_par;      // start node parity relative to its root
    logic [AW-1:0] r_root_a;
    logic          r_par_a;
    logic [AW:0]   r_clr;

    // Result state: sticky found flag and answer, per-word hit, join and emit.
    logic          r_found;
    logic [WW-1:0] r_answer;
    logic          r_hit, r_join, r_emit;

    // Memory ports.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [AW-1:0] rd_par;
    logic          rd_sp;

    assign rd_par = rdata[EW-1:1];
    assign rd_sp  = rdata[0];

    pufc_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [AW-1:0] start;
    assign start = i_cmd.sel_b ? AW'(r_nb) : AW'(r_na);

    // Memory address, data and walk register steering.
    always_comb begin
        we    = 1'b0;
        waddr = r_cur;
        wdata = {r_root, r_acc};
        raddr = r_cur;
        n_cur = r_cur;
        n_acc = r_acc;
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_clr[AW-1:0];
            wdata = {r_clr[AW-1:0], 1'b0};
        end else if (i_cmd.rd_start) begin
            raddr = start;
            n_cur = start;
            n_acc = 1'b0;
        end else if (i_cmd.rd_next) begin
            // rdata holds entry of r_cur; step toward root
            raddr = rd_par;
            n_cur = rd_par;
            n_acc = r_acc ^ rd_sp;
        end else if (i_cmd.fix_start) begin
            raddr = start;
            n_cur = start;
        end else if (i_cmd.fix_step) begin
            // rewrite r_cur to point at root with folded parity
            we    = 1'b1;
            wdata = {r_root, r_acc};
            raddr = rd_par;
            n_cur = rd_par;
            n_acc = r_acc ^ rd_sp;
        end else if (i_cmd.decide && r_root != r_root_a) begin
            we    = 1'b1;
            waddr = r_root;
            wdata = {r_root_a, ~(r_par_a ^ r_par)};
        end
    end

    // Range check on the captured nodes.
    logic a_ok, b_ok;
    assign a_ok = 17'(r_na) < 17'(NODE_COUNT);
    assign b_ok = 17'(r_nb) < 17'(NODE_COUNT);

    assign o_stat.clr_last = (r_clr == EW'((1 << AW) - 1));
    assign o_stat.valid_in = a_ok && b_ok && !r_found;
    assign o_stat.at_root  = (rd_par == r_cur);
    assign o_stat.fix_done = (r_cur == r_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_found  <= 1'b0;
            r_answer <= '0;
            r_emit   <= 1'b0;
        end else begin
            r_emit <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.decide && r_root == r_root_a && r_par_a == r_par) begin
                r_found  <= 1'b1;
                r_answer <= r_w;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_acc <= n_acc;
        if (i_cmd.load) begin
            r_na  <= i_node_a;
            r_nb  <= i_node_b;
            r_w   <= i_weight[WW-1:0];
            r_hit <= 1'b0;
            r_join <= 1'b0;
        end
        // Walk landed on a self-parent: keep root and the folded parity.
        if (i_cmd.fix_start) begin
            r_root <= r_cur;
            r_par  <= r_acc;
        end
        if (i_cmd.save_a) begin
            r_root_a <= r_root;
            r_par_a  <= r_par;
        end
        if (i_cmd.decide) begin
            r_hit  <= (r_root == r_root_a) && (r_par_a == r_par);
            r_join <= (r_root != r_root_a);
        end
    end

    assign o_conflict = r_emit & r_hit;
    assign o_merged   = r_emit & r_join;
    assign o_found    = r_found;
    assign o_answer   = WORD_W'(r_answer);
endmodule

/* hw/rtl/pufc_ctrl.sv */
`include "assert_macros.svh"
module pufc_ctrl
    import pufc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    output logic  o_strobe,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);
    t_state r_state, n_state;
    logic   r_fix_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_fix_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fix_b <= (n_state == ST_FIX_B);
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RD_A;
                end
            end
            ST_RD_A: begin
                if (i_stat.valid_in) begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = ST_WALK_A;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_WALK_A, ST_WALK_B: begin
                o_cmd.sel_b = (r_state == ST_WALK_B);
                if (i_stat.at_root) begin
                    o_cmd.fix_start = 1'b1;
                    n_state = (r_state == ST_WALK_A) ? ST_FIX_A : ST_FIX_B;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            ST_FIX_A: begin
                if (i_stat.fix_done) begin
                    o_cmd.save_a = 1'b1;
                    n_state      = ST_RD_B;
                end else begin
                    o_cmd.fix_step = 1'b1;
                end
            end
            ST_RD_B: begin
                o_cmd.sel_b    = 1'b1;
                o_cmd.rd_start = 1'b1;
                n_state        = ST_WALK_B;
            end
            ST_FIX_B: begin
                o_cmd.sel_b = 1'b1;
                if (i_stat.fix_done) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.fix_step = 1'b1;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                o_cmd.emit   = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_strobe = (r_state == ST_DONE);

    `ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "strobe while idle")
    `ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, o_cmd.load, busy && !o_strobe,
                 "word accepted but block not busy")
    `ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1,
                 $onehot0({o_cmd.rd_start, o_cmd.rd_next, o_cmd.fix_start, o_cmd.fix_step}),
                 "conflicting walk commands")
    `ASSERT_NEXT(a_fixb_track, i_clk, i_rst_n, r_state == ST_FIX_B, r_fix_b || r_state != ST_FIX_B,
                 "fix tracker lost")
endmodule

/* hw/rtl/parity_union_find_conflict.sv */
// Parity union-find conflict detector.
// Input: start/busy command channel. A word (i_node_a, i_node_b, i_weight)
//   is taken on a clock edge with start high and busy low.
// Output: o_strobe marks one cycle holding o_conflict, o_merged, o_found
//   and o_answer for that word. The receiver cannot stall; every result
//   is shown once.
// Operation: the word walks node a's parent chain (one memory read per
//   link), rewrites that chain for compression to point at the root,
//   then does the same for node b, then a decide step that joins the
//   roots or flags a conflict. The strobe follows the decide step, and
//   the next word is taken only after the strobe, once busy is low.
//   Out-of-range or post-conflict words skip the walks and go straight
//   to the result strobe. The node memory, one registered read per
//   cycle, sets the pace.
// Reset: i_rst_n (synchronous, low) starts a clearing pass writing each
//   of the 2**clog2(NODE_COUNT) node entries as its own root, with busy high.
// After the first conflict the store is frozen and o_answer holds the
//   conflicting weight.
module parity_union_find_conflict
    import pufc_pkg::*;
#(
    parameter int unsigned NODE_COUNT  = NODE_COUNT_DEF,
    parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [WORD_W-1:0] i_weight,
    output logic              o_strobe,
    output logic              o_conflict,
    output logic              o_merged,
    output logic              o_found,
    output logic [WORD_W-1:0] o_answer
);
    t_cmd  cmd;
    t_stat stat;

    pufc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    pufc_dp #(.NODE_COUNT(NODE_COUNT), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_node_a  (i_node_a),
        .i_node_b  (i_node_b),
        .i_weight  (i_weight),
        .o_conflict(o_conflict),
        .o_merged  (o_merged),
        .o_found   (o_found),
        .o_answer  (o_answer)
    );
endmodule

/* dv/pufc_checker.sv */
`timescale 1ns / 100ps

module pufc_checker
    import pufc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [WORD_W-1:0] i_weight,
    input  logic              o_strobe,
    input  logic              o_conflict,
    input  logic              o_merged,
    input  logic              o_found,
    input  logic [WORD_W-1:0] o_answer,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic              conflict;
        logic              merged;
        logic              found;
        logic [WORD_W-1:0] answer;
    } t_verdict;

    // Shadow forest: parent link and parity relative to the parent
    logic [NODE_W-1:0] link_mem [NODE_COUNT_DEF];
    logic              side_mem [NODE_COUNT_DEF];
    logic              latched;
    logic [WORD_W-1:0] latched_weight;
    t_verdict          verdict_q [$];

    assign o_pending = verdict_q.size();

    // Root of n, with path compression; side_mem[n] ends relative to root
    function automatic logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] root;
        logic [NODE_W-1:0] nxt;
        logic              acc;
        logic              old;
        cur = n;
        acc = 1'b0;
        while (link_mem[cur] != cur) begin
            acc ^= side_mem[cur];
            cur = link_mem[cur];
        end
        root = cur;
        cur = n;
        while (cur != root) begin
            nxt = link_mem[cur];
            old = side_mem[cur];
            side_mem[cur] = acc;
            link_mem[cur] = root;
            acc ^= old;
            cur = nxt;
        end
        return root;
    endfunction

    function automatic t_verdict judge_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                            logic [WORD_W-1:0] w);
        t_verdict v;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        v = '0;
        if (!latched) begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra == rb) begin
                if (side_mem[a] == side_mem[b]) begin
                    v.conflict = 1'b1;
                    latched = 1'b1;
                    latched_weight = w;
                end
            end else begin
                link_mem[rb] = ra;
                side_mem[rb] = ~(side_mem[a] ^ side_mem[b]);
                v.merged = 1'b1;
            end
        end
        v.found = latched;
        v.answer = latched_weight;
        return v;
    endfunction

    // Predict on each accepted word, compare each strobed result
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_COUNT_DEF; i++) begin
                link_mem[i] = NODE_W'(i);
                side_mem[i] = 1'b0;
            end
            latched = 1'b0;
            latched_weight = '0;
            verdict_q.delete();
            o_fail_count <= 0;
        end else begin
            if (o_strobe) begin
                got = '{o_conflict, o_merged, o_found, o_answer};
                if (verdict_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("%0t: expected %p, got %p", $realtime, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                verdict_q.push_back(judge_edge(i_node_a, i_node_b, i_weight));
        end
    end
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import pufc_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [NODE_W-1:0] i_node_a = '0;
    logic [NODE_W-1:0] i_node_b = '0;
    logic [WORD_W-1:0] i_weight = '0;
    logic              o_strobe;
    logic              o_conflict;
    logic              o_merged;
    logic              o_found;
    logic [WORD_W-1:0] o_answer;
    int                fail_count;
    int                pending;

    // Hidden two-coloring: edges across colors never conflict
    logic              color [NODE_COUNT_DEF];
    int                idle_pct;

    always #6 i_clk = ~i_clk;

    parity_union_find_conflict uut (.*);
    pufc_checker chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    // Present one word at the falling edge, hold until taken
    task automatic send_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic [WORD_W-1:0] w);
        logic taken;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_node_a <= a;
        i_node_b <= b;
        i_weight <= w;
        taken = 1'b0;
        while (!taken) begin
            #1;
            taken = !busy;
            @(negedge i_clk);
        end
    endtask

    // Word across the coloring, nodes drawn from a window of given span
    task automatic send_clean(int span);
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        int base;
        int tries;
        base = $urandom_range(NODE_COUNT_DEF - span);
        a = NODE_W'(base + $urandom_range(span - 1));
        tries = 0;
        do begin
            b = NODE_W'(base + $urandom_range(span - 1));
            tries++;
        end while (color[b] == color[a] && tries < 64);
        // Window of one color: pair with a fixed node of the other color
        if (color[b] == color[a])
            b = color[a] ? NODE_W'(0) : NODE_W'(1);
        send_edge(a, b, $urandom);
    endtask

    initial begin
        int phase;
        for (int i = 0; i < NODE_COUNT_DEF; i++)
            color[i] = $urandom_range(1);
        color[0] = 1'b0;
        color[1] = 1'b1;
        color[1022] = 1'b0;
        color[1023] = 1'b1;
        idle_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extreme nodes and weights, merges, already opposite
        send_edge(10'd0, 10'd1023, 32'hFFFF_FFFF);
        send_edge(10'd1, 10'd1022, 32'h0);
        send_edge(10'd0, 10'd1, 32'h8000_0001);
        send_edge(10'd1023, 10'd0, 32'h7FFF_FFFE);
        send_edge(10'd1022, 10'd1023, 32'h5555_5555);
        send_edge(10'd1, 10'd0, 32'hAAAA_AAAA);
        for (int i = 0; i < 12; i++)
            send_clean(8);

        // Random: well-formed edges, chains grown in narrow windows
        for (int n = 0; n < 1850; n++) begin
            phase = (n / 150) % 4;
            idle_pct = (phase == 0) ? 0 : (phase == 1) ? 88 : (phase == 2) ? 13 : 0;
            if (n == 900) begin
                start <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            case ($urandom_range(3))
                0: send_clean(NODE_COUNT_DEF);
                1: send_clean(64);
                default: send_clean(16);
            endcase
        end

        // Self edge conflicts unless frozen; then the frozen store
        idle_pct = 13;
        send_edge(NODE_W'($urandom), NODE_W'(0), 32'h0) ;
        send_edge(10'd5, 10'd5, $urandom);
        for (int i = 0; i < 40; i++)
            send_edge(NODE_W'($urandom), NODE_W'($urandom), $urandom);
        start <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
